// ===== design/b64enc_pkg.sv =====
package b64enc_pkg;

  localparam int MAX_CHARS = 6;
  localparam int CNT_W = 3;
  localparam int SYMS_PER_GROUP = 4;

  localparam logic [7:0] NL_CHAR = 8'h0A;
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [6:0] PAD_INDEX = 7'd64;
  localparam logic [7:0] MIN_LINE_LENGTH = 8'd4;
  localparam logic [7:0] RESET_LINE_LENGTH = 8'd76;

  typedef logic [7:0] char_t;
  typedef char_t [MAX_CHARS-1:0] char_list_t;

  typedef struct packed {
    logic [15:0] pend;
    logic [1:0]  gc;
    logic [7:0]  pos;
  } enc_state_t;

  // Maps a 6-bit symbol index, or the pad index, to its ASCII character.
  function automatic char_t sym_char(input logic [6:0] idx);
    char_t c;
    if (idx < 7'd26) begin
      c = 8'd65 + {1'b0, idx};
    end else if (idx < 7'd52) begin
      c = 8'd97 + {1'b0, idx} - 8'd26;
    end else if (idx < 7'd62) begin
      c = 8'd48 + {1'b0, idx} - 8'd52;
    end else if (idx == 7'd62) begin
      c = 8'h2B;
    end else if (idx == 7'd63) begin
      c = 8'h2F;
    end else begin
      c = PAD_CHAR;
    end
    return c;
  endfunction

endpackage

// ===== design/b64enc_core.sv =====
module b64enc_core (
  input  b64enc_pkg::enc_state_t st,
  input  logic [7:0]             line_length,
  input  logic [7:0]             data_byte,
  input  logic                   eos,
  output b64enc_pkg::enc_state_t st_next,
  output b64enc_pkg::char_list_t chars,
  output logic [2:0]             char_count
);
  import b64enc_pkg::*;

  logic [7:0]  lim;
  logic [15:0] pnew;
  logic [1:0]  gnew;
  logic        has_syms;
  logic [6:0]  sym_idx [SYMS_PER_GROUP];
  logic [7:0]  pos;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    lim = (line_length < MIN_LINE_LENGTH) ? MIN_LINE_LENGTH : line_length;
    pnew = {st.pend[7:0], data_byte};
    gnew = st.gc[1] ? 2'd0 : st.gc + 2'd1;
    has_syms = 1'b1;
    for (int i = 0; i < SYMS_PER_GROUP; i++) begin
      sym_idx[i] = PAD_INDEX;
    end

    if (st.gc[1]) begin
      sym_idx[0] = {1'b0, st.pend[15:10]};
      sym_idx[1] = {1'b0, st.pend[9:4]};
      sym_idx[2] = {1'b0, st.pend[3:0], data_byte[7:6]};
      sym_idx[3] = {1'b0, data_byte[5:0]};
    end else if (eos && gnew == 2'd1) begin
      sym_idx[0] = {1'b0, data_byte[7:2]};
      sym_idx[1] = {1'b0, data_byte[1:0], 4'b0000};
    end else if (eos) begin
      sym_idx[0] = {1'b0, pnew[15:10]};
      sym_idx[1] = {1'b0, pnew[9:4]};
      sym_idx[2] = {1'b0, pnew[3:0], 2'b00};
    end else begin
      has_syms = 1'b0;
    end

    chars = '0;
    cnt = '0;
    pos = st.pos;
    if (has_syms) begin
      for (int i = 0; i < SYMS_PER_GROUP; i++) begin
        chars[cnt] = sym_char(sym_idx[i]);
        cnt = cnt + 3'd1;
        pos = pos + 8'd1;
        if (pos >= lim) begin
          chars[cnt] = NL_CHAR;
          cnt = cnt + 3'd1;
          pos = '0;
        end
      end
    end
    if (eos) begin
      if (pos != 8'd0) begin
        chars[cnt] = NL_CHAR;
        cnt = cnt + 3'd1;
      end
      pos = '0;
    end

    char_count = cnt;
    st_next.pend = (st.gc[1] || eos) ? 16'd0 : pnew;
    st_next.gc = eos ? 2'd0 : gnew;
    st_next.pos = pos;
  end

endmodule

// ===== design/base64_stream_encoder.sv =====
// Base64 encoder with line wrapping. A request is held in an input register,
// then encoded in a single pass into a list of up to six characters.
// The list is registered, and its first character is offered once the output is free.
// One character per cycle out while m_axis_tready is high. A byte that only buffers gives
// no characters; after a byte with characters the next byte waits until its last is taken.
// Reset clears the byte buffer, group and line position and sets line_length to 76.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tlast,   // end_of_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast    // last_of_run
);
  import b64enc_pkg::*;

  logic [7:0] line_length;
  enc_state_t st;
  enc_state_t st_next;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;

  char_list_t list_chars;
  logic [CNT_W-1:0] list_count;
  logic [CNT_W-1:0] list_idx;

  char_list_t enc_chars;
  logic [CNT_W-1:0] enc_count;

  logic list_last;
  logic list_done;
  logic move;

  b64enc_core u_core (
    .st          (st),
    .line_length (line_length),
    .data_byte   (in_byte),
    .eos         (in_eos),
    .st_next     (st_next),
    .chars       (enc_chars),
    .char_count  (enc_count)
  );

  assign m_axis_tvalid = (list_count != '0);
  assign list_last = (list_idx == list_count - 3'd1);
  assign m_axis_tdata = list_chars[list_idx];
  assign m_axis_tlast = list_last;
  assign list_done = m_axis_tvalid && m_axis_tready && list_last;
  assign move = in_valid && (!m_axis_tvalid || list_done);
  assign s_axis_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= RESET_LINE_LENGTH;
    end else if (cfg_we) begin
      line_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eos <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      list_count <= '0;
      list_idx <= '0;
    end else begin
      if (move) begin
        st <= st_next;
        list_count <= enc_count;
        list_idx <= '0;
      end else if (list_done) begin
        list_count <= '0;
        list_idx <= '0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        list_idx <= list_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      list_chars <= enc_chars;
    end
  end

endmodule

// ===== tb/base64_stream_encoder_test.sv =====
module base64_stream_encoder_test;
  import b64enc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       hold;
  } byte_req_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  byte_req_t stim_q[$];
  byte_req_t next_req;
  enc_char_t chars_due[$];
  char_t     step_chars[$];
  enc_char_t got;
  enc_char_t want;

  string b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

  logic [15:0] enc_pending = 16'd0;
  logic [1:0]  enc_count = 2'd0;
  logic [7:0]  line_pos = 8'd0;
  logic [7:0]  line_len = RESET_LINE_LENGTH;

  int   bytes_taken = 0;
  int   bytes_offered = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatches = 0;
  int   cycles = 0;

  base64_stream_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Emits one symbol and wraps the line once it is full. A line length below
  // the minimum behaves as the minimum.
  task automatic put_symbol(input logic [6:0] idx);
    logic [7:0] limit;
    limit = (line_len < MIN_LINE_LENGTH) ? MIN_LINE_LENGTH : line_len;
    if (step_chars.size() < MAX_CHARS) step_chars.push_back(char_t'(b64_alphabet[idx]));
    line_pos = line_pos + 8'd1;
    if (line_pos >= limit) begin
      if (step_chars.size() < MAX_CHARS) step_chars.push_back(NL_CHAR);
      line_pos = 8'd0;
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic eos);
    logic [23:0] w;
    enc_char_t item;
    step_chars.delete();
    if (enc_count >= 2'd2) begin
      w = {enc_pending, b};
      put_symbol({1'b0, w[23:18]});
      put_symbol({1'b0, w[17:12]});
      put_symbol({1'b0, w[11:6]});
      put_symbol({1'b0, w[5:0]});
      enc_pending = 16'd0;
      enc_count = 2'd0;
    end else begin
      enc_pending = {enc_pending[7:0], b};
      enc_count = enc_count + 2'd1;
    end
    if (eos) begin
      if (enc_count == 2'd1) begin
        w = {enc_pending[7:0], 16'd0};
        put_symbol({1'b0, w[23:18]});
        put_symbol({1'b0, w[17:12]});
        put_symbol(PAD_INDEX);
        put_symbol(PAD_INDEX);
      end else if (enc_count == 2'd2) begin
        w = {enc_pending, 8'd0};
        put_symbol({1'b0, w[23:18]});
        put_symbol({1'b0, w[17:12]});
        put_symbol({1'b0, w[11:6]});
        put_symbol(PAD_INDEX);
      end
      if (line_pos != 8'd0 && step_chars.size() < MAX_CHARS) step_chars.push_back(NL_CHAR);
      enc_pending = 16'd0;
      enc_count = 2'd0;
      line_pos = 8'd0;
    end
    foreach (step_chars[k]) begin
      item.ch = step_chars[k];
      item.last = (k == step_chars.size() - 1);
      chars_due.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_stream_encoder_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ch = m_axis_tdata;
      got.last = m_axis_tlast;
      if (chars_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected character %h last %b", got.ch, got.last);
        mismatches = mismatches + 1;
      end else begin
        want = chars_due.pop_front();
        if (got.ch !== want.ch || got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("mismatch: char %h last %b, expected char %h last %b",
                     got.ch, got.last, want.ch, want.last);
          end
          mismatches = mismatches + 1;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      encode_byte(s_axis_tdata, s_axis_tlast);
      bytes_taken = bytes_taken + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (bytes_taken == bytes_offered) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(stim_q[0].hold && chars_due.size() != 0)) begin
        next_req = stim_q.pop_front();
        bytes_offered = bytes_offered + 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_req.data;
        s_axis_tlast <= next_req.eos;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send(input logic [7:0] data, input logic eos, input logic hold);
    byte_req_t r;
    r.data = data;
    r.eos = eos;
    r.hold = hold;
    stim_q.push_back(r);
  endtask

  // Waits until every request is taken and every character has come out, then
  // gives a buffering request time to finish inside the block.
  task automatic settle();
    do begin
      @(negedge clk);
      #1;
    end while (stim_q.size() != 0 || s_axis_tvalid || chars_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_length(input logic [7:0] len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    line_len = len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_streams(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        send(8'($urandom_range(255)), i == len - 1, $urandom_range(29) == 0);
      end
      sent = sent + len;
    end
  endtask

  task automatic random_phase(input logic [7:0] first_len);
    for (int c = 0; c < 3; c++) begin
      if (c == 0) begin
        set_line_length(first_len);
      end else if ($urandom_range(3) == 0) begin
        set_line_length(8'($urandom_range(4, 255)));
      end else begin
        set_line_length(8'($urandom_range(4, 12)));
      end
      random_streams(16);
      settle();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 88;

    set_line_length(8'd4);
    send(8'h00, 1'b1, 1'b0);
    send(8'hFF, 1'b0, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    send(8'hFB, 1'b0, 1'b1);
    send(8'hEF, 1'b0, 1'b0);
    send(8'hBE, 1'b0, 1'b0);
    send(8'hFF, 1'b0, 1'b0);
    send(8'hFF, 1'b0, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    send(8'h4D, 1'b0, 1'b0);
    send(8'h61, 1'b1, 1'b0);
    settle();

    // The line is left partly filled so that the shorter length applies mid-line.
    set_line_length(8'd255);
    for (int i = 1; i <= 7; i++) send(8'(i), 1'b0, 1'b0);
    settle();
    set_line_length(8'd5);
    send(8'h08, 1'b1, 1'b0);
    settle();

    set_line_length(8'd0);
    send(8'h80, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    settle();
    set_line_length(8'd3);
    send(8'h7F, 1'b1, 1'b0);
    settle();

    random_phase(8'd4);
    send_idle_pct = 88;
    recv_idle_pct = 6;
    random_phase(8'd255);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(RESET_LINE_LENGTH);

    if (mismatches == 0) begin
      $display("base64_stream_encoder_test: PASS");
    end else begin
      $display("base64_stream_encoder_test: FAIL");
    end
    $finish;
  end

endmodule
